// ===== sv/limit_order_book_matcher_unit_assert.svh =====
// ----------------------------------------------------------------------------
// limit order book matcher assertion macros
// clocked, reset-gated property checks used by the top level
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LOBM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// types, constants and slot addressing for the order book matcher
// ----------------------------------------------------------------------------
`default_nettype none
package lobm_pkg;
  localparam int INSTRUMENTS     = 4;
  localparam int ORDERS_PER_SIDE = 16;
  localparam int SLOT_COUNT      = INSTRUMENTS * 2 * ORDERS_PER_SIDE;
  localparam int SLOT_W          = $clog2(SLOT_COUNT);
  localparam int IDX_W           = $clog2(ORDERS_PER_SIDE);
  localparam int CNT_W           = $clog2(ORDERS_PER_SIDE + 1);

  localparam logic [2:0] KIND_FILL   = 3'd0;
  localparam logic [2:0] KIND_RESTED = 3'd1;
  localparam logic [2:0] KIND_FILLED = 3'd2;
  localparam logic [2:0] KIND_ZERO   = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic [30:0] order_id;
    logic        side;
    logic [23:0] quantity;
    logic [19:0] price_ticks;
    logic [1:0]  instrument;
  } order_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  book_index;
    logic [30:0] buyer_id;
    logic [30:0] seller_id;
    logic [23:0] traded_qty;
    logic [19:0] fill_price;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [30:0] id;
    logic [19:0] price;
    logic [23:0] qty;
    logic [31:0] seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FILL, ST_DONE} state_t;

  // slot number of entry idx on one side of one book
  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] inst,
                                               input logic sd,
                                               input logic [IDX_W-1:0] idx);
    int s;
    s = (int'(inst) * 2 + int'(sd)) * ORDERS_PER_SIDE + int'(idx);
    return SLOT_W'(s);
  endfunction
endpackage
`default_nettype wire

// ===== sv/lobm_ram.sv =====
// ----------------------------------------------------------------------------
// lobm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/limit_order_book_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// price-time priority matcher for several instrument books
// ----------------------------------------------------------------------------
// An order is taken when start is high and busy is low. Each result item
// appears on result for one cycle with strobe high; the receiver cannot stall,
// so it must take every strobed item. An order produces zero or more fills
// (last low) and one status item (last high). A zero quantity order is
// answered in the cycle after it is taken and busy stays low. Otherwise each
// pass over the opposite side reads its ORDERS_PER_SIDE entries from the
// entry ram one per cycle. A pass that finds a candidate is followed by a
// fill item and, while quantity remains, by a new pass; otherwise the status
// item closes the order. Valid bits live in flip-flops and are cleared by
// reset, so no clearing pass is needed.
`default_nettype none
module limit_order_book_matcher_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire lobm_pkg::order_t order,
  output logic                  busy,
  output logic                  strobe,
  output lobm_pkg::result_t     result
);
  import lobm_pkg::*;

  state_t state, state_next;

  // latched order
  logic [30:0] ord_id;
  logic        ord_side;
  logic [23:0] qty_rem;
  logic [19:0] ord_price;
  logic [1:0]  ord_inst;

  logic [SLOT_COUNT-1:0] valid;
  logic [31:0]           arrival_counter;

  // scan position and best candidate so far
  logic [CNT_W-1:0]  cnt;
  logic              best_found;
  logic [SLOT_W-1:0] best_slot;
  entry_t            best_entry;
  logic [31:0]       best_age;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  // ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            ram_rdata;

  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic accept;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // evaluation of the entry read in the previous scan cycle
  logic [IDX_W-1:0]  eval_idx;
  logic [SLOT_W-1:0] eval_slot, own_slot;
  logic              eval_on, eligible, better;
  logic [31:0]       eval_age;
  logic              take;

  assign eval_idx  = IDX_W'(cnt - CNT_W'(1));
  assign eval_slot = slot_of(ord_inst, ~ord_side, eval_idx);
  assign own_slot  = slot_of(ord_inst, ord_side, eval_idx);
  assign eval_on   = (state == ST_SCAN) && (cnt != '0);
  assign eval_age  = arrival_counter - ram_rdata.seq;

  always_comb begin
    // buy takes sells at or below its limit, sell takes buys at or above
    if (ord_side == SIDE_BUY) begin
      eligible = (ram_rdata.price <= ord_price);
      better   = (ram_rdata.price < best_entry.price);
    end else begin
      eligible = (ram_rdata.price >= ord_price);
      better   = (ram_rdata.price > best_entry.price);
    end
    // same price level: the older entry wins
    if (ram_rdata.price == best_entry.price && eval_age > best_age) begin
      better = 1'b1;
    end
    take = eval_on && valid[eval_slot] && eligible && (!best_found || better);
  end

  // fill quantity
  logic [23:0] fill_t;
  assign fill_t = (qty_rem < best_entry.qty) ? qty_rem : best_entry.qty;

  // status kind closing the order
  logic [2:0] done_kind;
  assign done_kind = (qty_rem == '0) ? KIND_FILLED :
                     (free_found ? KIND_RESTED : KIND_FULL);

  // next state, ram addressing
  always_comb begin
    state_next = state;
    ram_raddr  = slot_of(ord_inst, ~ord_side, cnt[IDX_W-1:0]);
    ram_we     = 1'b0;
    ram_waddr  = best_slot;
    ram_wdata  = best_entry;
    case (state)
      ST_IDLE: begin
        if (accept && order.quantity != '0) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(ORDERS_PER_SIDE)) begin
          state_next = (best_found || take) ? ST_FILL : ST_DONE;
        end
      end
      ST_FILL: begin
        // write back the reduced resting quantity
        ram_we        = 1'b1;
        ram_wdata.qty = best_entry.qty - fill_t;
        state_next    = (qty_rem == fill_t) ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        // rest the remainder in the lowest free slot of its own side
        if (qty_rem != '0 && free_found) begin
          ram_we    = 1'b1;
          ram_waddr = free_slot;
          ram_wdata = '{id: ord_id, price: ord_price, qty: qty_rem,
                        seq: arrival_counter};
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      valid           <= '0;
      arrival_counter <= '0;
      strobe          <= 1'b0;
      best_found      <= 1'b0;
      free_found      <= 1'b0;
      cnt             <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ord_id     <= order.order_id;
            ord_side   <= order.side;
            qty_rem    <= order.quantity;
            ord_price  <= order.price_ticks;
            ord_inst   <= 2'(order.instrument % INSTRUMENTS);
            cnt        <= '0;
            best_found <= 1'b0;
            free_found <= 1'b0;
            if (order.quantity == '0) begin
              strobe <= 1'b1;
              result <= '{kind: KIND_ZERO,
                          book_index: 2'(order.instrument % INSTRUMENTS),
                          buyer_id: order.order_id, seller_id: order.order_id,
                          traded_qty: '0, fill_price: '0, last: 1'b1};
            end
          end
        end
        ST_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (take) begin
            best_found <= 1'b1;
            best_slot  <= eval_slot;
            best_entry <= ram_rdata;
            best_age   <= eval_age;
          end
          if (eval_on && !free_found && !valid[own_slot]) begin
            free_found <= 1'b1;
            free_slot  <= own_slot;
          end
        end
        ST_FILL: begin
          strobe <= 1'b1;
          result <= '{kind: KIND_FILL, book_index: ord_inst,
                      buyer_id: (ord_side == SIDE_BUY) ? ord_id : best_entry.id,
                      seller_id: (ord_side == SIDE_BUY) ? best_entry.id : ord_id,
                      traded_qty: fill_t, fill_price: best_entry.price,
                      last: 1'b0};
          qty_rem    <= qty_rem - fill_t;
          if (best_entry.qty == fill_t) begin
            valid[best_slot] <= 1'b0;
          end
          cnt        <= '0;
          best_found <= 1'b0;
        end
        ST_DONE: begin
          strobe <= 1'b1;
          result <= '{kind: done_kind, book_index: ord_inst, buyer_id: ord_id,
                      seller_id: ord_id, traded_qty: qty_rem, fill_price: '0,
                      last: 1'b1};
          if (qty_rem != '0 && free_found) begin
            valid[free_slot] <= 1'b1;
            arrival_counter  <= arrival_counter + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `include "limit_order_book_matcher_unit_assert.svh"

  // a nonzero order always keeps the block busy next cycle
  `LOBM_ASSERT_NEXT(a_busy_after_take, accept && order.quantity != '0, busy, "not busy")
  // a fill is only issued with a candidate in hand
  `LOBM_ASSERT_IMPL(a_fill_has_best, state == ST_FILL, best_found, "fill without best")
  // a fill item never closes an order
  `LOBM_ASSERT_IMPL(a_fill_not_last, strobe && result.kind == KIND_FILL, !result.last, "fill last")
endmodule
`default_nettype wire
